// ===== rtl/core/gstd_pkg.sv =====
// Shared types, constants and the CORDIC angle table of the go-to-goal controller.
`default_nettype none

package gstd_pkg;

   // Datapath widths.
   localparam int XY_W       = 35;  // CORDIC x and y, room for the gain on a 32-bit offset
   localparam int Z_W        = 25;  // angle accumulator, 1/32768 degree
   localparam int SQ_W       = 64;  // squared length and square-root working words
   localparam int SQRT_STEPS = 32;  // one result bit of the root per cell
   localparam int POS_W      = 31;
   localparam int HEAD_W     = 16;
   localparam int DIST_W     = 21;

   // Angle constants.
   localparam logic [31:0]            NEAR_ZERO = 32'd655;        // 0.01 m in Q16
   localparam logic signed [Z_W-1:0]  QUARTER_Z = 25'sd2949120;   // 90 degrees, 1/32768 deg
   localparam logic signed [18:0]     HALF_TURN = 19'sd23040;     // 180 degrees, 1/128 deg
   localparam logic signed [18:0]     FULL_TURN = 19'sd46080;     // 360 degrees, 1/128 deg

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_GOAL_X        = 3'd0,
      CSR_GOAL_Y        = 3'd1,
      CSR_GOAL_HEADING  = 3'd2,
      CSR_ARRIVE_RADIUS = 3'd3,
      CSR_FINAL_TOL     = 3'd4,
      CSR_HEADING_TOL   = 3'd5,
      CSR_MAX_STEP      = 3'd6
   } csr_index_type;

   // Configuration register contents.
   typedef struct packed {
      logic signed [POS_W-1:0]  goal_x;
      logic signed [POS_W-1:0]  goal_y;
      logic signed [HEAD_W-1:0] goal_heading;
      logic [16:0]              arrive_radius;
      logic [14:0]              final_align_tolerance;
      logic [14:0]              heading_tolerance;
      logic [DIST_W-1:0]        max_step;
   } cfg_type;

   // Word handed from one cell to the next.
   typedef struct packed {
      logic                     vld;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
      logic [SQ_W-1:0]          rem;
      logic [SQ_W-1:0]          root;
      logic                     near;
      logic signed [HEAD_W-1:0] rh;
   } cell_data_type;

   // One command beat.
   typedef struct packed {
      logic                     at_goal;
      logic signed [HEAD_W-1:0] turn_angle;
      logic [DIST_W-1:0]        move_distance;
   } result_type;

   // Arctangent of 2^-i in 1/32768 degree, rounded; zero past the end of the table.
   function automatic logic signed [Z_W-1:0] ang_entry(input int idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         0:       a = 25'sd1474560;
         1:       a = 25'sd870484;
         2:       a = 25'sd459940;
         3:       a = 25'sd233473;
         4:       a = 25'sd117189;
         5:       a = 25'sd58652;
         6:       a = 25'sd29333;
         7:       a = 25'sd14667;
         8:       a = 25'sd7334;
         9:       a = 25'sd3667;
         10:      a = 25'sd1833;
         11:      a = 25'sd917;
         12:      a = 25'sd458;
         13:      a = 25'sd229;
         14:      a = 25'sd115;
         15:      a = 25'sd57;
         16:      a = 25'sd29;
         17:      a = 25'sd14;
         18:      a = 25'sd7;
         19:      a = 25'sd4;
         20:      a = 25'sd2;
         21:      a = 25'sd1;
         default: a = 25'sd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gstd_front.sv =====
// Front end: goal offset, pre-rotation, squares and squared length over three stages.
`default_nettype none

module gstd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_vld,
   input  wire logic signed [30:0]            robot_x,
   input  wire logic signed [30:0]            robot_y,
   input  wire logic signed [15:0]            robot_heading,
   input  wire gstd_pkg::cfg_type             cfg,
   output gstd_pkg::cell_data_type            data_out
);

   // Stage one: offset, magnitudes and quadrant fold.
   logic                                      s1_vld_ff;
   logic [31:0]                               s1_ux_ff, s1_ux_in;
   logic [31:0]                               s1_uy_ff, s1_uy_in;
   logic signed [gstd_pkg::XY_W-1:0]          s1_x_ff, s1_x_in;
   logic signed [gstd_pkg::XY_W-1:0]          s1_y_ff, s1_y_in;
   logic signed [gstd_pkg::Z_W-1:0]           s1_z_ff, s1_z_in;
   logic                                      s1_near_ff, s1_near_in;
   logic signed [15:0]                        s1_rh_ff;

   logic signed [31:0]                        dx, dy;
   logic signed [gstd_pkg::XY_W-1:0]          dx_w, dy_w;

   always_comb begin
      dx       = 32'(cfg.goal_x) - 32'(robot_x);
      dy       = 32'(cfg.goal_y) - 32'(robot_y);
      dx_w     = gstd_pkg::XY_W'(dx);
      dy_w     = gstd_pkg::XY_W'(dy);
      s1_ux_in = dx[31] ? 32'(-dx) : 32'(dx);
      s1_uy_in = dy[31] ? 32'(-dy) : 32'(dy);
      s1_near_in = (s1_ux_in <= gstd_pkg::NEAR_ZERO) && (s1_uy_in <= gstd_pkg::NEAR_ZERO);
      // Fold the left half plane into the right one by a quarter turn.
      if (dx[31] && !dy[31]) begin
         s1_x_in = dy_w;
         s1_y_in = -dx_w;
         s1_z_in = gstd_pkg::QUARTER_Z;
      end else if (dx[31]) begin
         s1_x_in = -dy_w;
         s1_y_in = dx_w;
         s1_z_in = -gstd_pkg::QUARTER_Z;
      end else begin
         s1_x_in = dx_w;
         s1_y_in = dy_w;
         s1_z_in = '0;
      end
   end

   // Stage two: the two squares.
   logic                                      s2_vld_ff;
   logic [63:0]                               s2_sqx_ff, s2_sqy_ff;
   logic signed [gstd_pkg::XY_W-1:0]          s2_x_ff, s2_y_ff;
   logic signed [gstd_pkg::Z_W-1:0]           s2_z_ff;
   logic                                      s2_near_ff;
   logic signed [15:0]                        s2_rh_ff;

   // Stage three: squared length, seeding the root recurrence.
   logic                                      s3_vld_ff;
   logic [63:0]                               s3_sum_ff;
   logic signed [gstd_pkg::XY_W-1:0]          s3_x_ff, s3_y_ff;
   logic signed [gstd_pkg::Z_W-1:0]           s3_z_ff;
   logic                                      s3_near_ff;
   logic signed [15:0]                        s3_rh_ff;

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // Payload of the three stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ux_ff   <= s1_ux_in;
         s1_uy_ff   <= s1_uy_in;
         s1_x_ff    <= s1_x_in;
         s1_y_ff    <= s1_y_in;
         s1_z_ff    <= s1_z_in;
         s1_near_ff <= s1_near_in;
         s1_rh_ff   <= robot_heading;

         s2_sqx_ff  <= 64'(s1_ux_ff) * 64'(s1_ux_ff);
         s2_sqy_ff  <= 64'(s1_uy_ff) * 64'(s1_uy_ff);
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_z_ff    <= s1_z_ff;
         s2_near_ff <= s1_near_ff;
         s2_rh_ff   <= s1_rh_ff;

         s3_sum_ff  <= s2_sqx_ff + s2_sqy_ff;
         s3_x_ff    <= s2_x_ff;
         s3_y_ff    <= s2_y_ff;
         s3_z_ff    <= s2_z_ff;
         s3_near_ff <= s2_near_ff;
         s3_rh_ff   <= s2_rh_ff;
      end
   end

   always_comb begin
      data_out.vld  = s3_vld_ff;
      data_out.x    = s3_x_ff;
      data_out.y    = s3_y_ff;
      data_out.z    = s3_z_ff;
      data_out.rem  = s3_sum_ff;
      data_out.root = '0;
      data_out.near = s3_near_ff;
      data_out.rh   = s3_rh_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/gstd_cell.sv =====
// One cell of the chain: a CORDIC vectoring step and one digit of the integer square root.
`default_nettype none

module gstd_cell #(
   parameter int IDX           = 0,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire gstd_pkg::cell_data_type cell_i,
   output gstd_pkg::cell_data_type      cell_o
);

   localparam logic signed [gstd_pkg::Z_W-1:0] ANG   = gstd_pkg::ang_entry(IDX);
   localparam logic [gstd_pkg::SQ_W-1:0]       BIT_V = 64'd1 << (62 - 2 * IDX);

   gstd_pkg::cell_data_type            data_ff, data_in;
   logic signed [gstd_pkg::XY_W-1:0]   xs, ys;
   logic [gstd_pkg::SQ_W-1:0]          trial;

   // Next cell word.
   always_comb begin
      data_in = cell_i;
      xs      = cell_i.x >>> IDX;
      ys      = cell_i.y >>> IDX;
      // Rotate toward the x axis; cells past the stage count only pass the angle on.
      if (IDX < CORDIC_STAGES) begin
         if (cell_i.y > 0) begin
            data_in.x = cell_i.x + ys;
            data_in.y = cell_i.y - xs;
            data_in.z = cell_i.z + ANG;
         end else begin
            data_in.x = cell_i.x - ys;
            data_in.y = cell_i.y + xs;
            data_in.z = cell_i.z - ANG;
         end
      end
      // Restoring square-root digit.
      trial = cell_i.root + BIT_V;
      if (cell_i.rem >= trial) begin
         data_in.rem  = cell_i.rem - trial;
         data_in.root = (cell_i.root >> 1) + BIT_V;
      end else begin
         data_in.root = cell_i.root >> 1;
      end
   end

   // Valid bit and payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.vld <= 1'b0;
      end else if (adv) begin
         data_ff.vld <= data_in.vld;
      end
      if (adv) begin
         data_ff.x    <= data_in.x;
         data_ff.y    <= data_in.y;
         data_ff.z    <= data_in.z;
         data_ff.rem  <= data_in.rem;
         data_ff.root <= data_in.root;
         data_ff.near <= data_in.near;
         data_ff.rh   <= data_in.rh;
      end
   end

   assign cell_o = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gstd_decide.sv =====
// Decision stage: bearing rounding, angle wrap and the turn, drive or done choice.
`default_nettype none

module gstd_decide (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire gstd_pkg::cell_data_type cell_i,
   input  wire gstd_pkg::cfg_type       cfg,
   output logic                         res_vld,
   output gstd_pkg::result_type         res
);

   logic                       vld_ff;
   gstd_pkg::result_type       res_ff, res_in;

   logic [31:0]                dist_q16;
   logic signed [25:0]         z_rnd;
   logic signed [17:0]         bearing;
   logic signed [18:0]         eb, eb_a, eb_w;
   logic signed [18:0]         ea, ea_a, ea_w;
   logic [14:0]                eb_mag, ea_mag;

   always_comb begin
      dist_q16 = cell_i.root[31:0];
      // Round the accumulated angle to 1/128 degree.
      z_rnd   = 26'(cell_i.z) + 26'sd128;
      bearing = cell_i.near ? 18'sd0 : z_rnd[25:8];

      // Error toward the bearing, one wrap each way.
      eb   = 19'(bearing) - 19'(cell_i.rh);
      eb_a = (eb > gstd_pkg::HALF_TURN) ? eb - gstd_pkg::FULL_TURN : eb;
      eb_w = (eb_a < -gstd_pkg::HALF_TURN) ? eb_a + gstd_pkg::FULL_TURN : eb_a;
      eb_mag = eb_w[18] ? 15'(-eb_w) : 15'(eb_w);

      // Error toward the final heading; one wrap covers the whole 16-bit span.
      ea   = 19'(cfg.goal_heading) - 19'(cell_i.rh);
      ea_a = (ea > gstd_pkg::HALF_TURN) ? ea - gstd_pkg::FULL_TURN : ea;
      ea_w = (ea_a < -gstd_pkg::HALF_TURN) ? ea_a + gstd_pkg::FULL_TURN : ea_a;
      ea_mag = ea_w[18] ? 15'(-ea_w) : 15'(ea_w);

      res_in.at_goal       = 1'b0;
      res_in.turn_angle    = '0;
      res_in.move_distance = '0;
      if (dist_q16 < 32'(cfg.arrive_radius)) begin
         if (ea_mag < cfg.final_align_tolerance) begin
            res_in.at_goal = 1'b1;
         end else begin
            res_in.turn_angle = 16'(ea_w);
         end
      end else if (eb_mag <= cfg.heading_tolerance) begin
         res_in.move_distance = (dist_q16 > 32'(cfg.max_step)) ? cfg.max_step
                                                               : gstd_pkg::DIST_W'(dist_q16);
      end else begin
         res_in.turn_angle = 16'(eb_w);
      end
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= cell_i.vld;
      end
   end

   // Command register.
   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign res_vld = vld_ff;
   assign res     = res_ff;

endmodule

`default_nettype wire

// ===== rtl/core/goal_seek_turn_then_drive.sv =====
// Top level of the go-to-goal controller: registers, cell chain and output buffer.
//
// Usage: each req_ beat carries one robot pose (x, y in Q15.16 metres, heading in
// 1/128 degree). Each pose gives exactly one rsp_ beat: at_goal, turn_angle and
// move_distance, in the order the poses came in. Goal and tolerances sit in seven
// registers written over the csr_ channel (index 0 goal_x up to index 6 max_step;
// index 7 is dropped); csr_ready is always high and writes belong to idle periods.
// A pose on its way to rsp_valid passes three front stages (offset, squares,
// sum), a chain of 32 cells that each resolve one root bit and, for the first
// CORDIC_STAGES cells, one CORDIC step, one decision stage and the output
// register. Throughput is one pose per cycle while req_stall is low.
// When the receiver stalls, the command waits in the output register and the next
// one lands in a skid register; once that is full, req_stall rises and the whole
// pipeline holds. req_stall comes straight from a flip-flop.
// Reset (synchronous, active high) empties the pipeline and returns the registers
// to goal (0, 0), heading 0, radius 0.1 m, tolerances 20 and 10 degrees, step 0.5 m.
`default_nettype none

module goal_seek_turn_then_drive #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Pose beats.
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [30:0] req_robot_x,
   input  wire logic signed [30:0] req_robot_y,
   input  wire logic signed [15:0] req_robot_heading,
   // Command beats.
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_at_goal,
   output logic signed [15:0]      rsp_turn_angle,
   output logic [20:0]             rsp_move_distance,
   // Register writes.
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [30:0]        csr_data
);

   gstd_pkg::cfg_type              cfg_ff;
   logic                           adv;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.goal_x                <= '0;
         cfg_ff.goal_y                <= '0;
         cfg_ff.goal_heading          <= '0;
         cfg_ff.arrive_radius         <= 17'd6554;
         cfg_ff.final_align_tolerance <= 15'd2560;
         cfg_ff.heading_tolerance     <= 15'd1280;
         cfg_ff.max_step              <= 21'd32768;
      end else if (csr_valid && csr_ready) begin
         case (gstd_pkg::csr_index_type'(csr_index))
            gstd_pkg::CSR_GOAL_X:        cfg_ff.goal_x                <= csr_data;
            gstd_pkg::CSR_GOAL_Y:        cfg_ff.goal_y                <= csr_data;
            gstd_pkg::CSR_GOAL_HEADING:  cfg_ff.goal_heading          <= csr_data[15:0];
            gstd_pkg::CSR_ARRIVE_RADIUS: cfg_ff.arrive_radius         <= csr_data[16:0];
            gstd_pkg::CSR_FINAL_TOL:     cfg_ff.final_align_tolerance <= csr_data[14:0];
            gstd_pkg::CSR_HEADING_TOL:   cfg_ff.heading_tolerance     <= csr_data[14:0];
            gstd_pkg::CSR_MAX_STEP:      cfg_ff.max_step              <= csr_data[20:0];
            default: begin
            end
         endcase
      end
   end

   // Front end feeding the first cell.
   gstd_pkg::cell_data_type        chain [0:gstd_pkg::SQRT_STEPS];

   gstd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_vld        (req_valid && !req_stall),
      .robot_x       (req_robot_x),
      .robot_y       (req_robot_y),
      .robot_heading (req_robot_heading),
      .cfg           (cfg_ff),
      .data_out      (chain[0])
   );

   // Chain of cells.
   for (genvar i = 0; i < gstd_pkg::SQRT_STEPS; i++) begin : g_cell
      gstd_cell #(
         .IDX           (i),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .cell_i (chain[i]),
         .cell_o (chain[i+1])
      );
   end

   // Decision stage.
   logic                           dec_vld;
   gstd_pkg::result_type           dec_res;

   gstd_decide u_decide (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .cell_i  (chain[gstd_pkg::SQRT_STEPS]),
      .cfg     (cfg_ff),
      .res_vld (dec_vld),
      .res     (dec_res)
   );

   // Output register with a skid register behind it.
   logic                           out_vld_ff, out_vld_in;
   gstd_pkg::result_type           out_ff, out_in;
   logic                           skid_vld_ff, skid_vld_in;
   gstd_pkg::result_type           skid_ff, skid_in;

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || !rsp_stall) begin
         // Output register free this cycle: the skid beat goes first.
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = dec_vld;
            out_in     = dec_res;
         end
      end else if (dec_vld && adv) begin
         skid_vld_in = 1'b1;
         skid_in     = dec_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_at_goal       = out_ff.at_goal;
   assign rsp_turn_angle    = out_ff.turn_angle;
   assign rsp_move_distance = out_ff.move_distance;

   // The skid register only fills behind a held output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register full while output register is empty");

   // Arrival means no motion of any kind.
   a_done_no_motion: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_at_goal) |-> (rsp_turn_angle == 16'sd0 && rsp_move_distance == 21'd0))
      else $error("at_goal beat carries a turn or a move");

   // Driving and turning never share a beat.
   a_drive_no_turn: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_move_distance != 21'd0) |-> (rsp_turn_angle == 16'sd0 && !rsp_at_goal))
      else $error("move beat also carries a turn or at_goal");

   // A move never exceeds the configured step.
   a_move_limited: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_move_distance <= cfg_ff.max_step))
      else $error("move distance above max_step");

endmodule

`default_nettype wire
